FILE: sv/cmosrtc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CMOS RTC register file package
// Shared types, register indexes, reset values and the update sequence table.
// ----------------------------------------------------------------------------
package cmosrtc_pkg;

    localparam int CMOSRTC_RAM_DEPTH = 64;

    typedef enum logic [2:0] {
        CMD_SELECT = 3'd0,
        CMD_WRITE  = 3'd1,
        CMD_READ   = 3'd2,
        CMD_UPDATE = 3'd3,
        CMD_RESET  = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RD,
        ST_RESULT
    } state_t;

    localparam logic [7:0] REG_A          = 8'h0A;
    localparam logic [7:0] REG_B          = 8'h0B;
    localparam logic [7:0] REG_C          = 8'h0C;
    localparam logic [7:0] REG_D          = 8'h0D;
    localparam logic [7:0] REG_CENTURY    = 8'h32;
    localparam logic [7:0] NUM_TIME_REGS  = 8'd10;

    localparam logic [7:0] RESET_A        = 8'd32;
    localparam logic [7:0] RESET_B        = 8'd2;
    localparam logic [7:0] RESET_D        = 8'd128;
    localparam logic [7:0] BYTE_ABSENT    = 8'hFF;
    localparam logic [7:0] CENTURY_VALUE  = 8'd21;
    localparam logic [7:0] YEAR_OFFSET    = 8'd20;

    localparam int         LOAD_STEPS     = 8;
    localparam int         STEP_W         = $clog2(LOAD_STEPS);
    localparam logic [STEP_W-1:0] STEP_HOUR = STEP_W'(2);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(LOAD_STEPS - 1);

    typedef struct packed {
        logic       clr;
        logic       we;
        logic [7:0] waddr;
        logic [7:0] wdata;
        logic       re;
        logic [7:0] raddr;
    } ram_req_t;

    function automatic logic [7:0] reset_byte(input logic [7:0] addr);
        logic [7:0] value;
        case (addr)
            REG_A:   value = RESET_A;
            REG_B:   value = RESET_B;
            REG_D:   value = RESET_D;
            default: value = 8'd0;
        endcase
        return value;
    endfunction

    function automatic logic [7:0] load_addr(input logic [STEP_W-1:0] step);
        logic [7:0] addr;
        case (step)
            3'd0:    addr = 8'd0;
            3'd1:    addr = 8'd2;
            3'd2:    addr = 8'd4;
            3'd3:    addr = 8'd6;
            3'd4:    addr = 8'd7;
            3'd5:    addr = 8'd8;
            3'd6:    addr = 8'd9;
            default: addr = REG_CENTURY;
        endcase
        return addr;
    endfunction

endpackage

FILE: sv/cmosrtc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CMOS RTC byte store
// Single-write, single-read synchronous RAM with per-entry valid bits; an
// entry that is not valid reads as its power-on value.
// ----------------------------------------------------------------------------
module cmosrtc_ram
    import cmosrtc_pkg::*;
#(
    parameter int RAM_DEPTH = CMOSRTC_RAM_DEPTH,
    parameter int AW        = $clog2(RAM_DEPTH)
) (
    input  logic       clk,
    input  logic       rstn,
    input  ram_req_t   req,
    output logic [7:0] rdata
);

    logic [7:0]           mem [RAM_DEPTH];
    logic [RAM_DEPTH-1:0] valid_reg;
    logic [7:0]           mem_q_reg;
    logic                 vld_q_reg;
    logic [7:0]           dflt_q_reg;
    logic [AW-1:0]        waddr;
    logic [AW-1:0]        raddr;

    assign waddr = req.waddr[AW-1:0];
    assign raddr = req.raddr[AW-1:0];

    always_ff @(posedge clk) begin
        if (req.we) begin
            mem[waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn || req.clr) begin
            valid_reg <= '0;
        end else if (req.we) begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (req.re) begin
            dflt_q_reg <= reset_byte(8'(raddr));
            if (req.we && waddr == raddr) begin
                mem_q_reg <= req.wdata;
                vld_q_reg <= 1'b1;
            end else begin
                mem_q_reg <= mem[raddr];
                vld_q_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = vld_q_reg ? mem_q_reg : dflt_q_reg;

endmodule

FILE: sv/cmosrtc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CMOS RTC command sequencer
// Decodes requests, runs the eight-step time load through the RAM write port
// and returns read bytes through an output register.
// ----------------------------------------------------------------------------
module cmosrtc_ctrl
    import cmosrtc_pkg::*;
#(
    parameter int RAM_DEPTH = CMOSRTC_RAM_DEPTH
) (
    input  logic       clk,
    input  logic       rstn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_cmd,
    input  logic [7:0] s_data,
    input  logic [5:0] s_now_second,
    input  logic [5:0] s_now_minute,
    input  logic [4:0] s_now_hour,
    input  logic [2:0] s_now_weekday,
    input  logic [4:0] s_now_day,
    input  logic [3:0] s_now_month,
    input  logic [6:0] s_now_year,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data,
    output ram_req_t   ram_req,
    input  logic [7:0] ram_rdata
);

    state_t              state_reg, state_next;
    logic [7:0]          sel_reg, sel_next;
    logic                pend_reg, pend_next;
    logic [7:0]          b_reg, b_next;
    logic                lfr_reg, lfr_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [7:0]          hold_reg, hold_next;
    logic                m_valid_reg, m_valid_next;
    logic [7:0]          m_data_reg, m_data_next;
    logic [5:0]          sec_reg, sec_next;
    logic [5:0]          min_reg, min_next;
    logic [4:0]          hour_reg, hour_next;
    logic [2:0]          wday_reg, wday_next;
    logic [4:0]          day_reg, day_next;
    logic [3:0]          mon_reg, mon_next;
    logic [6:0]          year_reg, year_next;
    logic                in_range;
    logic [7:0]          step_value;

    function automatic logic [7:0] fmt_value(input logic [7:0] v, input logic hour,
                                             input logic [7:0] breg);
        logic [7:0]  x;
        logic        pm;
        logic [15:0] prod;
        logic [4:0]  q;
        logic [7:0]  tens;
        logic [7:0]  r;
        x  = v;
        pm = 1'b0;
        if (hour && !breg[1]) begin
            if (x == 8'd0) begin
                x = 8'd12;
            end else if (x == 8'd12) begin
                pm = 1'b1;
            end else if (x > 8'd12) begin
                x  = x - 8'd12;
                pm = 1'b1;
            end
        end
        if (!breg[2]) begin
            prod = 16'(x) * 16'd205;
            q    = prod[15:11];
            tens = {q[4:0], 3'b000} + {2'b00, q[4:0], 1'b0};
            r    = x - tens;
            x    = {q[3:0], r[3:0]};
        end
        return x | {pm, 7'b0000000};
    endfunction

    assign in_range = {1'b0, sel_reg} < 9'(RAM_DEPTH);
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        case (step_reg)
            3'd0:    step_value = {2'b00, sec_reg};
            3'd1:    step_value = {2'b00, min_reg};
            3'd2:    step_value = {3'b000, hour_reg};
            3'd3:    step_value = {5'b00000, wday_reg} + 8'd1;
            3'd4:    step_value = {3'b000, day_reg};
            3'd5:    step_value = {4'b0000, mon_reg} + 8'd1;
            3'd6:    step_value = {1'b0, year_reg} + YEAR_OFFSET;
            default: step_value = CENTURY_VALUE;
        endcase
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg   <= ST_IDLE;
            sel_reg     <= REG_D;
            pend_reg    <= 1'b0;
            b_reg       <= RESET_B;
            lfr_reg     <= 1'b0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sel_reg     <= sel_next;
            pend_reg    <= pend_next;
            b_reg       <= b_next;
            lfr_reg     <= lfr_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        hold_reg   <= hold_next;
        m_data_reg <= m_data_next;
        sec_reg    <= sec_next;
        min_reg    <= min_next;
        hour_reg   <= hour_next;
        wday_reg   <= wday_next;
        day_reg    <= day_next;
        mon_reg    <= mon_next;
        year_reg   <= year_next;
    end

    always_comb begin
        state_next   = state_reg;
        sel_next     = sel_reg;
        pend_next    = pend_reg;
        b_next       = b_reg;
        lfr_next     = lfr_reg;
        step_next    = step_reg;
        hold_next    = hold_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        sec_next     = sec_reg;
        min_next     = min_reg;
        hour_next    = hour_reg;
        wday_next    = wday_reg;
        day_next     = day_reg;
        mon_next     = mon_reg;
        year_next    = year_reg;
        ram_req      = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    sec_next  = s_now_second;
                    min_next  = s_now_minute;
                    hour_next = s_now_hour;
                    wday_next = s_now_weekday;
                    day_next  = s_now_day;
                    mon_next  = s_now_month;
                    year_next = s_now_year;
                    unique case (cmd_t'(s_cmd))
                        CMD_SELECT: begin
                            sel_next = s_data;
                        end
                        CMD_WRITE: begin
                            if (in_range && sel_reg != REG_C && sel_reg != REG_D) begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = sel_reg;
                                ram_req.wdata = (sel_reg == REG_A) ? (s_data & 8'h7F)
                                                                   : s_data;
                                if (sel_reg == REG_B) begin
                                    b_next = s_data;
                                end
                            end
                        end
                        CMD_READ: begin
                            if (!in_range) begin
                                hold_next  = BYTE_ABSENT;
                                state_next = ST_RESULT;
                            end else if (pend_reg && !b_reg[7] && sel_reg < NUM_TIME_REGS) begin
                                pend_next  = 1'b0;
                                lfr_next   = 1'b1;
                                step_next  = '0;
                                state_next = ST_LOAD;
                            end else begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = sel_reg;
                                state_next    = ST_RD;
                            end
                        end
                        CMD_UPDATE: begin
                            pend_next = 1'b1;
                        end
                        CMD_RESET: begin
                            ram_req.clr = 1'b1;
                            sel_next    = REG_D;
                            pend_next   = 1'b0;
                            b_next      = RESET_B;
                            lfr_next    = 1'b0;
                            step_next   = '0;
                            state_next  = ST_LOAD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOAD: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = load_addr(step_reg);
                ram_req.wdata = fmt_value(step_value, step_reg == STEP_HOUR, b_reg);
                step_next     = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST) begin
                    if (lfr_reg) begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = sel_reg;
                        state_next    = ST_RD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RD: begin
                hold_next  = ram_rdata;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = hold_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid     = m_valid_reg;
    assign m_read_data = m_data_reg;

    a_load_steps: assert property (@(posedge clk) disable iff (!rstn)
        (state_reg == ST_LOAD && step_reg != STEP_LAST) |=>
            (state_reg == ST_LOAD && step_reg == $past(step_reg) + STEP_W'(1)))
        else $error("Time load sequence skipped a step.");

    a_no_pending_in_load: assert property (@(posedge clk) disable iff (!rstn)
        (state_reg == ST_LOAD) |-> !pend_reg)
        else $error("Update request still pending during a time load.");

    a_no_write_cd: assert property (@(posedge clk) disable iff (!rstn)
        (state_reg == ST_IDLE && ram_req.we) |->
            (ram_req.waddr != REG_C && ram_req.waddr != REG_D))
        else $error("Host write reached register C or D.");

    a_reg_a_bit7: assert property (@(posedge clk) disable iff (!rstn)
        (ram_req.we && ram_req.waddr == REG_A) |-> !ram_req.wdata[7])
        else $error("Register A written with bit 7 set.");

    a_result_held: assert property (@(posedge clk) disable iff (!rstn)
        (state_reg == ST_RESULT && m_valid_reg && !m_ready) |=>
            (state_reg == ST_RESULT && m_valid_reg))
        else $error("Read byte lost while the output was stalled.");

endmodule

FILE: sv/cmos_rtc_register_file_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CMOS RTC register file
// Index-addressed 64-byte real-time-clock register file with time update.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ channel (valid/ready) as a command, a data byte and
// the host time fields. Select, write and update requests complete without
// leaving the idle state. A read returns one byte on the m_ channel
// (valid/ready); the byte passes through the RAM read register, a hold register
// and the output register, and the input is not ready again until the byte is
// in the output register. A read above the store depth returns 0xFF through the
// hold and output registers without a RAM access. A read of a time register
// with an update pending and SET clear first writes the eight time bytes
// serially through the single RAM write port and then reads the RAM. A reset
// request clears the store through its valid bits and then loads the time
// bytes. After aresetn the store holds its power-on contents (register A 32,
// B 2, D 128, the rest zero), register D is selected and no update is pending.
// A finished read byte waits in the output register while the receiver
// stalls; further requests that produce no byte are still taken meanwhile,
// and a following read waits until the output register is free.
// ----------------------------------------------------------------------------
module cmos_rtc_register_file_top
    import cmosrtc_pkg::*;
#(
    parameter int RAM_DEPTH = CMOSRTC_RAM_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_cmd,
    input  logic [7:0] s_data,
    input  logic [5:0] s_now_second,
    input  logic [5:0] s_now_minute,
    input  logic [4:0] s_now_hour,
    input  logic [2:0] s_now_weekday,
    input  logic [4:0] s_now_day,
    input  logic [3:0] s_now_month,
    input  logic [6:0] s_now_year,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data
);

    ram_req_t   ram_req;
    logic [7:0] ram_rdata;

    cmosrtc_ctrl #(
        .RAM_DEPTH(RAM_DEPTH)
    ) u_ctrl (
        .clk          (aclk),
        .rstn         (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_data       (s_data),
        .s_now_second (s_now_second),
        .s_now_minute (s_now_minute),
        .s_now_hour   (s_now_hour),
        .s_now_weekday(s_now_weekday),
        .s_now_day    (s_now_day),
        .s_now_month  (s_now_month),
        .s_now_year   (s_now_year),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (m_read_data),
        .ram_req      (ram_req),
        .ram_rdata    (ram_rdata)
    );

    cmosrtc_ram #(
        .RAM_DEPTH(RAM_DEPTH)
    ) u_ram (
        .clk  (aclk),
        .rstn (aresetn),
        .req  (ram_req),
        .rdata(ram_rdata)
    );

endmodule
